/* rtl/b64e_pkg.sv */
`timescale 1ns / 1ps

package b64e_pkg;

    // one raw message byte with its end flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } t_in_beat;

    // one encoded character
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       message_last;
    } t_out_beat;

    // work for one input byte: up to four characters, already encoded
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            msg_end;
    } t_job;

    // front to queue
    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    localparam logic [7:0] CHAR_PAD   = 8'h3d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;

    // standard alphabet lookup
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            sextet_char = CHAR_UPPER + w;
        end else if (v < 6'd52) begin
            sextet_char = CHAR_LOWER + (w - 8'd26);
        end else if (v < 6'd62) begin
            sextet_char = CHAR_DIGIT + (w - 8'd52);
        end else if (v == 6'd62) begin
            sextet_char = CHAR_PLUS;
        end else begin
            sextet_char = CHAR_SLASH;
        end
    endfunction

endpackage

/* rtl/b64e_front.sv */
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_data,
    input  logic     i_full,
    output t_push    o_push
);

    logic [1:0] r_phase;
    logic [3:0] r_left;
    logic [1:0] n_phase;
    logic [3:0] n_left;
    logic       w_take;
    t_job       w_job;
    logic [7:0] w_b;
    logic       w_end;

    assign w_take = i_valid && !i_full;
    assign w_b    = i_data.data_byte;
    assign w_end  = i_data.message_end;

    // split the byte into characters by group position
    always_comb begin
        w_job.msg_end  = w_end;
        w_job.chars[2] = CHAR_PAD;
        w_job.chars[3] = CHAR_PAD;
        unique case (r_phase)
            PHASE_1: begin
                w_job.chars[0] = sextet_char({r_left[1:0], w_b[7:4]});
                w_job.chars[1] = sextet_char({w_b[3:0], 2'b00});
                w_job.last_idx = w_end ? 2'd2 : 2'd0;
                n_phase        = PHASE_2;
                n_left         = w_b[3:0];
            end
            PHASE_2: begin
                w_job.chars[0] = sextet_char({r_left, w_b[7:6]});
                w_job.chars[1] = sextet_char(w_b[5:0]);
                w_job.last_idx = 2'd1;
                n_phase        = PHASE_0;
                n_left         = 4'd0;
            end
            default: begin
                w_job.chars[0] = sextet_char(w_b[7:2]);
                w_job.chars[1] = sextet_char({w_b[1:0], 4'b0000});
                w_job.last_idx = w_end ? 2'd3 : 2'd0;
                n_phase        = PHASE_1;
                n_left         = {2'b00, w_b[1:0]};
            end
        endcase
        if (w_end) begin
            n_phase = PHASE_0;
            n_left  = 4'd0;
        end
    end

    // group position and carried bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_0;
            r_left  <= 4'd0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    assign o_push.push = w_take;
    assign o_push.job  = w_job;

    // a final byte always closes the group
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_end |=> r_phase == PHASE_0 && r_left == 4'd0)
        else $error("phase not cleared after final byte");

    // phase two never carries leftover bits into a new group
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PHASE_0 |-> r_left == 4'd0 || $past(r_phase) == PHASE_0)
        else $error("stale leftover bits at group start");

endmodule

/* rtl/b64e_queue.sv */
`timescale 1ns / 1ps

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rd];
    assign w_pop        = i_pop && o_head.valid;

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (w_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (i_push.push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push.push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && o_full))
        else $error("push into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue level out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 || r_cnt == CW'(DEPTH) |-> r_wr == r_rd)
        else $error("queue pointers disagree with level");

endmodule

/* rtl/b64e_back.sv */
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_beat o_data,
    input  logic      i_stall
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_beat  r_data;
    logic       w_free;
    logic       w_load;
    logic       w_run_last;

    assign w_free     = !r_valid || !i_stall;
    assign w_load     = w_free && i_head.valid;
    assign w_run_last = (r_idx == i_head.job.last_idx);
    assign o_pop      = w_load && w_run_last;

    // character index within the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (w_load) begin
            r_idx <= w_run_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data.out_char     <= i_head.job.chars[r_idx];
            r_data.run_last     <= w_run_last;
            r_data.message_last <= w_run_last && i_head.job.msg_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> r_idx <= i_head.job.last_idx)
        else $error("character index past end of job");

    a_msg_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.message_last |-> o_data.run_last)
        else $error("message end without run end");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head.valid |-> r_idx == 2'd0)
        else $error("index left mid job with empty queue");

endmodule

/* rtl/base64_stream_encoder_unit.sv */
`timescale 1ns / 1ps

// the first character of a byte is registered in the job queue, then in the output register
// throughput: one character per cycle at the output register while i_stall is low; a byte
// yields 1, 1 or 2 characters (up to 4 on the final byte)
// a two-entry job queue lets the front take bytes while the back drains characters
// reset: synchronous active low, clears group phase, queue and output valid

module base64_stream_encoder_unit
    import b64e_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_beat o_data,
    input  logic      i_stall
);

    t_push   w_push;
    t_q_head w_head;
    logic    w_full;
    logic    w_pop;

    assign o_stall = w_full;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    b64e_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
